FILE: hw/rtl/tsc_pkg.sv
package tsc_pkg;

    localparam int CPUS_DEF        = 8;
    localparam int CORE_W          = 3;
    localparam int ADDR_W          = 32;
    localparam int PAGES_W         = 32;
    localparam int GEN_W           = 32;
    localparam int TICKS_W         = 32;
    localparam int MISS_W          = 8;
    localparam int KIND_W          = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;
    localparam int IN_TDATA_W      = 72;
    localparam int OUT_TDATA_W     = 80;

    localparam logic [PAGES_W-1:0] PAGE_LIMIT_RST = 32'd64;
    localparam logic [TICKS_W-1:0] TIMEOUT_RST    = 32'd2000;
    localparam logic [PAGES_W-1:0] FLUSH_ALL      = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

    typedef enum logic [1:0] {
        OP_ONLINE  = 2'd0,
        OP_SHOOT   = 2'd1,
        OP_SERVICE = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INVAL    = 3'd0,
        KIND_IPI      = 3'd1,
        KIND_COMPLETE = 3'd2,
        KIND_BUSY     = 3'd3,
        KIND_TIMEOUT  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        RES_BUSY     = 3'd0,
        RES_INV_IN   = 3'd1,
        RES_INV_SVC  = 3'd2,
        RES_IPI      = 3'd3,
        RES_COMPLETE = 3'd4,
        RES_TIMEOUT  = 3'd5
    } res_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     do_online;
        logic     do_start;
        logic     do_service;
        logic     do_dec;
        logic     do_halt;
        logic     scan_clr;
        logic     scan_inc;
        logic     emit;
        logic     last;
        res_sel_t res_sel;
    } tsc_cmd_t;

    typedef struct packed {
        op_t  op;
        logic halted;
        logic core_ok;
        logic pages_zero;
        logic busy;
        logic lone;
        logic served_eq;
        logic svc_ack;
        logic svc_done;
        logic deadline_zero;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } tsc_status_t;

endpackage

FILE: hw/rtl/tsc_ctrl.sv
module tsc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tsc_pkg::tsc_status_t status,
    output tsc_pkg::tsc_cmd_t    cmd
);
    import tsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BUSY_RES,
        ST_LOCAL_INV,
        ST_SCAN,
        ST_SVC_INV,
        ST_COMPLETE,
        ST_TIMEOUT
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        cmd         = '0;
        cmd.res_sel = RES_BUSY;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                if (!status.halted && status.core_ok) begin
                    unique case (status.op)
                        OP_ONLINE: begin
                            cmd.do_online = 1'b1;
                        end
                        OP_SHOOT: begin
                            priority if (status.pages_zero) begin
                                state_next = ST_IDLE;
                            end else if (status.busy) begin
                                state_next = ST_BUSY_RES;
                            end else if (status.lone) begin
                                state_next = ST_LOCAL_INV;
                            end else begin
                                cmd.do_start = 1'b1;
                                cmd.scan_clr = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                        OP_SERVICE: begin
                            if (!status.served_eq) begin
                                cmd.do_service = 1'b1;
                                pend_next      = status.svc_ack && status.svc_done;
                                state_next     = ST_SVC_INV;
                            end
                        end
                        OP_TICK: begin
                            if (status.busy) begin
                                if (status.deadline_zero) begin
                                    state_next = ST_TIMEOUT;
                                end else begin
                                    cmd.do_dec = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_BUSY_RES: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.res_sel = RES_BUSY;
                    state_next  = ST_IDLE;
                end
            end
            ST_LOCAL_INV: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.res_sel = RES_INV_IN;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!status.scan_hit || status.out_free) begin
                    if (status.scan_hit) begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RES_IPI;
                    end
                    if (status.scan_end) begin
                        state_next = ST_LOCAL_INV;
                    end else begin
                        cmd.scan_inc = 1'b1;
                    end
                end
            end
            ST_SVC_INV: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.last    = !pend_reg;
                    cmd.res_sel = RES_INV_SVC;
                    state_next  = pend_reg ? ST_COMPLETE : ST_IDLE;
                end
            end
            ST_COMPLETE: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.res_sel = RES_COMPLETE;
                    state_next  = ST_IDLE;
                end
            end
            ST_TIMEOUT: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.last    = 1'b1;
                    cmd.do_halt = 1'b1;
                    cmd.res_sel = RES_TIMEOUT;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: hw/rtl/tsc_dp.sv
module tsc_dp #(
    parameter int CPUS = tsc_pkg::CPUS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [tsc_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  tsc_pkg::tsc_cmd_t                 cmd,
    output tsc_pkg::tsc_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [tsc_pkg::KIND_W-1:0]        m_tuser,
    output logic                              m_tlast
);
    import tsc_pkg::*;

    localparam int IW = $clog2(CPUS);

    logic [PAGES_W-1:0] page_limit_reg;
    logic [TICKS_W-1:0] timeout_reg;

    op_t                op_reg;
    logic [CORE_W-1:0]  core_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PAGES_W-1:0] pages_reg;

    logic [GEN_W-1:0]   live_reg;
    logic [GEN_W-1:0]   served_reg [CPUS];
    logic [CPUS-1:0]    online_reg;
    logic [CPUS-1:0]    target_reg;
    logic [CPUS-1:0]    ack_reg;
    logic [ADDR_W-1:0]  lat_addr_reg;
    logic [PAGES_W-1:0] lat_pages_reg;
    logic               busy_reg;
    logic [TICKS_W-1:0] deadline_reg;
    logic               halted_reg;
    logic [IW-1:0]      scan_reg;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [CORE_W-1:0]  out_core_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [PAGES_W-1:0] out_pages_reg;
    logic               out_flush_reg;
    logic [MISS_W-1:0]  out_miss_reg;
    logic               out_last_reg;

    logic [IW-1:0]      core_idx;
    logic [CPUS-1:0]    core_bit;
    logic [CPUS-1:0]    targets;
    logic [CPUS-1:0]    served_match;
    logic [GEN_W-1:0]   live_next;
    logic               core_ok;

    kind_t              res_kind;
    logic [CORE_W-1:0]  res_core;
    logic [ADDR_W-1:0]  res_addr;
    logic [PAGES_W-1:0] res_pages;
    logic               res_flush;
    logic [MISS_W-1:0]  res_miss;
    logic [ADDR_W-1:0]  inv_addr;
    logic [PAGES_W-1:0] inv_pages;
    logic               inv_flush;

    assign core_idx  = IW'(core_reg);
    assign core_ok   = (32'(core_reg) < 32'(CPUS));
    assign core_bit  = core_ok ? ({{(CPUS-1){1'b0}}, 1'b1} << core_idx) : '0;
    assign targets   = online_reg & ~core_bit;
    assign live_next = live_reg + 1'b1;

    always_comb begin
        for (int c = 0; c < CPUS; c++) begin
            served_match[c] = (served_reg[c] == live_reg);
        end
    end

    always_comb begin
        status.op            = op_reg;
        status.halted        = halted_reg;
        status.core_ok       = core_ok;
        status.pages_zero    = (pages_reg == '0);
        status.busy          = busy_reg;
        status.lone          = (targets == '0);
        status.served_eq     = served_match[core_idx];
        status.svc_ack       = busy_reg && ((target_reg & core_bit) != '0);
        status.svc_done      = ((ack_reg | core_bit) == target_reg);
        status.deadline_zero = (deadline_reg == '0);
        status.scan_hit      = target_reg[scan_reg];
        status.scan_end      = (scan_reg == IW'(CPUS - 1));
        status.out_free      = !out_valid_reg || m_tready;
    end

    // per-page range or full flush
    assign inv_addr  = (cmd.res_sel == RES_INV_IN) ? addr_reg : lat_addr_reg;
    assign inv_pages = (cmd.res_sel == RES_INV_IN) ? pages_reg : lat_pages_reg;
    assign inv_flush = (inv_pages == FLUSH_ALL) || (inv_pages > page_limit_reg);

    always_comb begin
        res_kind  = KIND_BUSY;
        res_core  = '0;
        res_addr  = '0;
        res_pages = '0;
        res_flush = 1'b0;
        res_miss  = '0;
        unique case (cmd.res_sel)
            RES_BUSY: begin
                res_kind = KIND_BUSY;
                res_core = core_reg;
            end
            RES_INV_IN, RES_INV_SVC: begin
                res_kind  = KIND_INVAL;
                res_core  = core_reg;
                res_flush = inv_flush;
                res_addr  = inv_flush ? '0 : inv_addr;
                res_pages = inv_flush ? '0 : inv_pages;
            end
            RES_IPI: begin
                res_kind = KIND_IPI;
                res_core = CORE_W'(scan_reg);
            end
            RES_COMPLETE: begin
                res_kind = KIND_COMPLETE;
            end
            RES_TIMEOUT: begin
                res_kind = KIND_TIMEOUT;
                res_miss = MISS_W'(target_reg & ~served_match);
            end
            default: begin
                res_kind = KIND_BUSY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg <= PAGE_LIMIT_RST;
            timeout_reg    <= TIMEOUT_RST;
            live_reg       <= '0;
            for (int c = 0; c < CPUS; c++) begin
                served_reg[c] <= '0;
            end
            online_reg     <= '0;
            target_reg     <= '0;
            ack_reg        <= '0;
            lat_addr_reg   <= '0;
            lat_pages_reg  <= '0;
            busy_reg       <= 1'b0;
            deadline_reg   <= '0;
            halted_reg     <= 1'b0;
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PAGE_LIMIT: page_limit_reg <= cfg_wdata;
                    CFG_TIMEOUT:    timeout_reg    <= cfg_wdata;
                endcase
            end
            if (cmd.do_online) begin
                served_reg[core_idx] <= live_reg;
                online_reg           <= online_reg | core_bit;
            end
            if (cmd.do_start) begin
                lat_addr_reg         <= addr_reg;
                lat_pages_reg        <= pages_reg;
                live_reg             <= live_next;
                served_reg[core_idx] <= live_next;
                target_reg           <= targets;
                ack_reg              <= '0;
                busy_reg             <= 1'b1;
                deadline_reg         <= timeout_reg;
            end
            if (cmd.do_service) begin
                served_reg[core_idx] <= live_reg;
                if (status.svc_ack) begin
                    ack_reg <= ack_reg | core_bit;
                    if (status.svc_done) begin
                        busy_reg <= 1'b0;
                    end
                end
            end
            if (cmd.do_dec) begin
                deadline_reg <= deadline_reg - 1'b1;
            end
            if (cmd.do_halt) begin
                halted_reg <= 1'b1;
            end
            if (cmd.scan_clr) begin
                scan_reg <= '0;
            end else if (cmd.scan_inc) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= op_t'(s_tdata[1:0]);
            core_reg  <= s_tdata[4:2];
            addr_reg  <= s_tdata[36:5];
            pages_reg <= s_tdata[68:37];
        end
        if (cmd.emit) begin
            out_kind_reg  <= res_kind;
            out_core_reg  <= res_core;
            out_addr_reg  <= res_addr;
            out_pages_reg <= res_pages;
            out_flush_reg <= res_flush;
            out_miss_reg  <= res_miss;
            out_last_reg  <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_miss_reg, out_flush_reg, out_pages_reg,
                                    out_addr_reg, out_core_reg});
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_busy_has_targets: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (target_reg != '0))
        else $error("busy with empty target set");

    a_acks_within_targets: assert property (@(posedge aclk) disable iff (!aresetn)
        (ack_reg & ~target_reg) == '0)
        else $error("acknowledge from a non-target core");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_timeout_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_kind_reg == KIND_TIMEOUT)) |-> halted_reg)
        else $error("timeout shown while not halted");

endmodule

FILE: hw/rtl/tlb_shootdown_coordinator.sv
// an accepted transfer is registered, then decoded, then its first result is registered
// in the output register, for ipi shootdowns once the scan reaches the lowest target core
// an item with no result frees the input after decode; one result, once it is emitted
// a shootdown scans the target set one core per cycle, held while an ipi waits for output
// one item at a time, bounded by the ipi scan over the cores
// synchronous active-low reset: control state cleared, page_limit 64, timeout_ticks 2000
module tlb_shootdown_coordinator #(
    parameter int CPUS = tsc_pkg::CPUS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation, core, virt_addr, page_count
    input  logic [tsc_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // target_core, range_addr, range_pages, full_flush, missing_mask
    output logic [tsc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // kind
    output logic [tsc_pkg::KIND_W-1:0]        m_tuser,
    output logic                              m_tlast
);
    import tsc_pkg::*;

    tsc_cmd_t    cmd;
    tsc_status_t status;

    tsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tsc_dp #(
        .CPUS (CPUS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: tb/shootdown_checker.sv
`timescale 1ns / 100ps

module shootdown_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // operation, core, virt_addr, page_count
    input  logic [tsc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // target_core, range_addr, range_pages, full_flush, missing_mask
    input  logic [tsc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // kind
    input  logic [tsc_pkg::KIND_W-1:0]          m_tuser,
    input  logic                                m_tlast,
    output int                                  failures,
    output int                                  outstanding
);
    import tsc_pkg::*;

    localparam int NCORES = CPUS_DEF;

    typedef struct {
        kind_t              kind;
        logic [CORE_W-1:0]  core;
        logic [ADDR_W-1:0]  addr;
        logic [PAGES_W-1:0] pages;
        logic               flush;
        logic [MISS_W-1:0]  missing;
        logic               last;
    } shoot_result_t;

    shoot_result_t expected_results[$];

    logic [PAGES_W-1:0] page_limit;
    logic [TICKS_W-1:0] timeout_ticks;
    logic [GEN_W-1:0]   live_gen;
    logic [GEN_W-1:0]   served_gen[NCORES];
    logic [NCORES-1:0]  online_cores;
    logic [NCORES-1:0]  pending_cores;
    int unsigned        pending_total;
    int unsigned        acks_seen;
    logic [ADDR_W-1:0]  held_addr;
    logic [PAGES_W-1:0] held_pages;
    logic               busy;
    logic               halted;
    logic [TICKS_W-1:0] ticks_left;
    int                 fail_count = 0;

    assign failures = fail_count;

    task automatic add_result(kind_t k, logic [CORE_W-1:0] c, logic [ADDR_W-1:0] a,
                              logic [PAGES_W-1:0] p, logic f, logic [MISS_W-1:0] m);
        shoot_result_t r;
        r.kind = k;
        r.core = c;
        r.addr = a;
        r.pages = p;
        r.flush = f;
        r.missing = m;
        r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    task automatic add_invalidate(logic [CORE_W-1:0] c, logic [ADDR_W-1:0] a,
                                  logic [PAGES_W-1:0] p);
        if (p == FLUSH_ALL || p > page_limit) begin
            add_result(KIND_INVAL, c, '0, '0, 1'b1, '0);
        end else begin
            add_result(KIND_INVAL, c, a, p, 1'b0, '0);
        end
    endtask

    task automatic predict_transfer(logic [IN_TDATA_W-1:0] d);
        op_t                op;
        logic [CORE_W-1:0]  c;
        logic [ADDR_W-1:0]  a;
        logic [PAGES_W-1:0] p;
        logic [NCORES-1:0]  tgt;
        logic [MISS_W-1:0]  miss;
        int                 base;
        op = op_t'(d[1:0]);
        c = d[4:2];
        a = d[36:5];
        p = d[68:37];
        base = expected_results.size();
        miss = '0;
        if (!halted) begin
            case (op)
                OP_ONLINE: begin
                    served_gen[c] = live_gen;
                    online_cores[c] = 1'b1;
                end
                OP_SHOOT: begin
                    if (p != '0) begin
                        if (busy) begin
                            add_result(KIND_BUSY, c, '0, '0, 1'b0, '0);
                        end else begin
                            tgt = online_cores & ~(NCORES'(1) << c);
                            if (tgt != '0) begin
                                held_addr = a;
                                held_pages = p;
                                live_gen = live_gen + 32'd1;
                                served_gen[c] = live_gen;
                                pending_cores = tgt;
                                pending_total = $countones(tgt);
                                acks_seen = 0;
                                busy = 1'b1;
                                ticks_left = timeout_ticks;
                                for (int i = 0; i < NCORES; i++) begin
                                    if (tgt[i]) begin
                                        add_result(KIND_IPI, CORE_W'(i), '0, '0, 1'b0, '0);
                                    end
                                end
                            end
                            add_invalidate(c, a, p);
                        end
                    end
                end
                OP_SERVICE: begin
                    if (served_gen[c] != live_gen) begin
                        add_invalidate(c, held_addr, held_pages);
                        served_gen[c] = live_gen;
                        if (busy && pending_cores[c]) begin
                            acks_seen++;
                            if (acks_seen >= pending_total) begin
                                busy = 1'b0;
                                add_result(KIND_COMPLETE, '0, '0, '0, 1'b0, '0);
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (busy) begin
                        if (ticks_left != '0) begin
                            ticks_left = ticks_left - 32'd1;
                        end else begin
                            for (int i = 0; i < NCORES; i++) begin
                                if (pending_cores[i] && served_gen[i] != live_gen) miss[i] = 1'b1;
                            end
                            add_result(KIND_TIMEOUT, '0, '0, '0, 1'b0, miss);
                            halted = 1'b1;
                        end
                    end
                end
            endcase
        end
        if (expected_results.size() > base) begin
            expected_results[expected_results.size()-1].last = 1'b1;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_transfer();
        shoot_result_t want;
        if (expected_results.size() == 0) begin
            $error("kind: expected no transfer, got %0h", m_tuser);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(m_tuser));
            check_field("target_core", 32'(want.core), 32'(m_tdata[2:0]));
            check_field("range_addr", want.addr, m_tdata[34:3]);
            check_field("range_pages", want.pages, m_tdata[66:35]);
            check_field("full_flush", 32'(want.flush), 32'(m_tdata[67]));
            check_field("missing_mask", 32'(want.missing), 32'(m_tdata[75:68]));
            check_field("last", 32'(want.last), 32'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            page_limit = PAGE_LIMIT_RST;
            timeout_ticks = TIMEOUT_RST;
            live_gen = '0;
            foreach (served_gen[i]) served_gen[i] = '0;
            online_cores = '0;
            pending_cores = '0;
            pending_total = 0;
            acks_seen = 0;
            held_addr = '0;
            held_pages = '0;
            busy = 1'b0;
            halted = 1'b0;
            ticks_left = '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PAGE_LIMIT: page_limit = cfg_wdata;
                    CFG_TIMEOUT:    timeout_ticks = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_transfer(s_tdata);
            if (m_tvalid && m_tready) check_transfer();
        end
        outstanding <= expected_results.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import tsc_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // operation, core, virt_addr, page_count
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // target_core, range_addr, range_pages, full_flush, missing_mask
    logic [OUT_TDATA_W-1:0] m_tdata;
    // kind
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    int failures;
    int outstanding;
    int items_sent = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    always #5 aclk = ~aclk;

    tlb_shootdown_coordinator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    shootdown_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= !stalls_on || ($urandom_range(99) >= 28);
    end

    function automatic logic [PAGES_W-1:0] rand_pages();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(1, 80);
        if (r < 70) return $urandom();
        if (r < 80) return FLUSH_ALL;
        if (r < 88) return 32'hFFFF_FFFE;
        if (r < 93) return '0;
        return 32'd1 << $urandom_range(31);
    endfunction

    task automatic send(op_t op, logic [CORE_W-1:0] c, logic [ADDR_W-1:0] a,
                        logic [PAGES_W-1:0] p);
        while (gaps_on && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, p, a, c, op};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_regs(logic [CFG_DATA_W-1:0] limit, logic [CFG_DATA_W-1:0] ticks);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PAGE_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one shootdown with noise, then every core services in random order, some skipped in a broken round
    task automatic run_round(inout bit clean);
        int order[8];
        int j;
        int tmp;
        bit broken;
        if (clean) begin
            repeat ($urandom_range(0, 2)) send(OP_ONLINE, 3'($urandom_range(7)), $urandom(),
                                               $urandom());
        end
        send(OP_SHOOT, 3'($urandom_range(7)), $urandom(), rand_pages());
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(2))
                0: send(OP_TICK, 3'($urandom_range(7)), $urandom(), $urandom());
                1: send(OP_SHOOT, 3'($urandom_range(7)), $urandom(), rand_pages());
                default: send(OP_SERVICE, 3'($urandom_range(7)), $urandom(), $urandom());
            endcase
        end
        for (int i = 0; i < 8; i++) order[i] = i;
        for (int i = 7; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        broken = $urandom_range(99) < 15;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(99) < 20) begin
                send(OP_TICK, 3'($urandom_range(7)), $urandom(), $urandom());
            end
            if (!(broken && $urandom_range(1))) begin
                send(OP_SERVICE, 3'(order[i]), $urandom(), $urandom());
            end
        end
        clean = !broken;
    endtask

    task automatic run_rounds(int goal);
        bit clean;
        clean = 1'b1;
        while (items_sent < goal) run_round(clean);
    endtask

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int base;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send(OP_TICK, 3'd0, '0, '0);
        send(OP_SERVICE, 3'd3, '0, '0);
        send(OP_SHOOT, 3'd0, 32'hFFFF_FFFF, FLUSH_ALL);
        for (int i = 0; i < 6; i++) send(OP_ONLINE, 3'(i), '0, '0);
        send(OP_SHOOT, 3'd4, 32'h1234_5000, '0);
        send(OP_SHOOT, 3'd2, '0, 32'd65);
        send(OP_SHOOT, 3'd1, 32'hFFFF_FFFF, FLUSH_ALL);
        send(OP_TICK, 3'd7, '0, '0);
        send(OP_SERVICE, 3'd6, '0, '0);
        send(OP_SERVICE, 3'd0, '0, '0);
        send(OP_SERVICE, 3'd1, '0, '0);
        send(OP_SERVICE, 3'd3, '0, '0);
        send(OP_SERVICE, 3'd4, '0, '0);
        send(OP_SERVICE, 3'd5, '0, '0);
        send(OP_SHOOT, 3'd3, 32'hFFFF_F000, 32'd64);
        send(OP_SERVICE, 3'd0, '0, '0);
        send(OP_SERVICE, 3'd1, '0, '0);
        send(OP_SERVICE, 3'd2, '0, '0);
        send(OP_SERVICE, 3'd4, '0, '0);
        send(OP_SERVICE, 3'd5, '0, '0);
        send(OP_SERVICE, 3'd7, '0, '0);
        base = items_sent;

        run_rounds(base + 125);

        drain();
        write_regs('0, 32'hFFFF_FFFF);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        run_rounds(base + 250);

        drain();
        write_regs(32'hFFFF_FFFE, 32'd3000);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        run_rounds(base + 365);

        // deadline runs out with one ack in, then everything is ignored
        drain();
        write_regs(32'd5, 32'd1);
        for (int i = 0; i < 8; i++) send(OP_SERVICE, 3'(i), '0, '0);
        for (int i = 0; i < 8; i++) send(OP_ONLINE, 3'(i), '0, '0);
        send(OP_SHOOT, 3'd0, $urandom(), 32'd3);
        send(OP_SERVICE, 3'd1, '0, '0);
        send(OP_TICK, 3'd0, '0, '0);
        send(OP_TICK, 3'd0, '0, '0);
        send(OP_TICK, 3'd0, '0, '0);
        send(OP_SHOOT, 3'd2, $urandom(), 32'd1);

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_ctrl.sv
hw/rtl/tsc_dp.sv
hw/rtl/tlb_shootdown_coordinator.sv
tb/shootdown_checker.sv
tb/tb.sv
